### design/lop_pkg.sv
// Package for the link option string parser: character codes, parser phases,
// the flag set and the result layout. No dependencies.
`timescale 1ns / 1ps

package lop_pkg;

  localparam int unsigned NUMBER_WIDTH_DEF = 32;
  localparam int unsigned FIELD_WIDTH      = 32;
  localparam int unsigned IN_DATA_WIDTH    = 8;
  localparam int unsigned OUT_DATA_WIDTH   = 112;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UP_C  = 8'h43;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_K  = 8'h4B;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_UP_U  = 8'h55;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_P  = 8'h70;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_U  = 8'h75;

  localparam logic [1:0] PROTO_NONE = 2'd0;
  localparam logic [1:0] PROTO_TCP  = 2'd1;
  localparam logic [1:0] PROTO_UDP  = 2'd2;

  typedef enum logic [2:0] {
    PH_SEEK   = 3'd0,
    PH_LETTER = 3'd1,
    PH_FRESH  = 3'd2,
    PH_BLANK  = 3'd3,
    PH_SIGNED = 3'd4,
    PH_DIGITS = 3'd5,
    PH_DONE   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    LT_C = 2'd0,
    LT_L = 2'd1,
    LT_E = 2'd2,
    LT_S = 2'd3
  } letter_e;

  typedef struct packed {
    phase_e  phase;
    letter_e pend;
    logic    neg;
  } ctrl_t;

  typedef struct packed {
    logic       shape;
    logic       legacy;
    logic       enc;
    logic       lzo;
    logic       zlib;
    logic       keep;
    logic [1:0] protocol;
    logic [3:0] type_mask;
  } flags_t;

  // The last member sits in the lowest bits.
  typedef struct packed {
    logic [FIELD_WIDTH-1:0] speed_out;
    logic                   shape_on;
    logic                   legacy_cipher;
    logic [FIELD_WIDTH-1:0] cipher_code;
    logic                   encrypt_on;
    logic [FIELD_WIDTH-1:0] comp_level;
    logic                   lzo_on;
    logic                   zlib_on;
    logic                   keep_alive;
    logic [3:0]             type_mask;
    logic [1:0]             protocol;
    logic                   ok;
  } result_t;

  localparam int unsigned RESULT_WIDTH = $bits(result_t);

endpackage

### design/lop_core.sv
// Parser core: the parse state registers and the one-character step logic.
// Depends on lop_pkg.
`timescale 1ns / 1ps

module lop_core
  import lop_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  logic [7:0] char_i,
  input  logic       start_i,
  output logic       res_valid_o,
  output result_t    res_o,
  output phase_e     phase_o
);

  localparam int unsigned NW = NUMBER_WIDTH;
  localparam logic [NW+3:0] LIM_NEG = {{4{1'b0}}, 1'b1, {(NW - 1){1'b0}}};
  localparam logic [NW+3:0] LIM_POS = LIM_NEG - (NW + 4)'(1);

  ctrl_t                 ctrl_q, ctrl_d, cur_ctrl;
  flags_t                flags_q, flags_d, cur_flags;
  logic [NW-1:0]         acc_q, acc_d, cur_acc;
  logic signed [NW-1:0]  level_q, level_d, cur_level;
  logic signed [NW-1:0]  cipher_q, cipher_d, cur_cipher;
  logic signed [NW-1:0]  speed_q, speed_d, cur_speed;
  logic signed [NW-1:0]  commit_val;
  logic [NW+3:0]         acc_next;
  logic [NW+3:0]         limit;
  logic                  is_blank, is_digit, is_sign;
  logic                  digit_step, do_commit, do_letter;
  logic                  emit, emit_ok;

  assign is_blank = (char_i == CH_SPACE) || ((char_i >= CH_TAB) && (char_i <= CH_CR));
  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_sign  = (char_i == CH_PLUS) || (char_i == CH_MINUS);

  always_comb begin : next_state
    cur_ctrl   = start_i ? '{phase: PH_SEEK, pend: LT_C, neg: 1'b0} : ctrl_q;
    cur_flags  = start_i ? '0 : flags_q;
    cur_acc    = start_i ? '0 : acc_q;
    cur_level  = start_i ? '0 : level_q;
    cur_cipher = start_i ? '0 : cipher_q;
    cur_speed  = start_i ? '0 : speed_q;

    ctrl_d     = cur_ctrl;
    flags_d    = cur_flags;
    acc_d      = cur_acc;
    level_d    = cur_level;
    cipher_d   = cur_cipher;
    speed_d    = cur_speed;
    emit       = 1'b0;
    emit_ok    = 1'b0;
    digit_step = 1'b0;
    do_commit  = 1'b0;
    do_letter  = 1'b0;
    commit_val = '0;

    acc_next = ({4'b0000, cur_acc} << 3) + ({4'b0000, cur_acc} << 1)
             + (NW + 4)'(char_i - CH_ZERO);
    limit    = cur_ctrl.neg ? LIM_NEG : LIM_POS;

    case (cur_ctrl.phase)
      PH_SEEK: begin
        if (char_i == CH_LT) begin
          ctrl_d.phase = PH_LETTER;
        end else if (char_i == CH_NUL) begin
          emit = 1'b1;
        end
      end
      PH_LETTER: begin
        do_letter = 1'b1;
      end
      PH_FRESH: begin
        if (is_blank) begin
          ctrl_d.phase = PH_BLANK;
        end else if (is_sign) begin
          ctrl_d.neg   = (char_i == CH_MINUS);
          ctrl_d.phase = PH_SIGNED;
        end else if (is_digit) begin
          digit_step = 1'b1;
        end else if (cur_ctrl.pend != LT_E) begin
          emit = 1'b1;
        end else begin
          do_commit = 1'b1;
          do_letter = 1'b1;
        end
      end
      PH_BLANK: begin
        if (is_sign) begin
          ctrl_d.neg   = (char_i == CH_MINUS);
          ctrl_d.phase = PH_SIGNED;
        end else if (is_digit) begin
          digit_step = 1'b1;
        end else if (!is_blank) begin
          emit = 1'b1;
        end
      end
      PH_SIGNED: begin
        if (is_digit) begin
          digit_step = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          digit_step = 1'b1;
        end else begin
          do_commit  = 1'b1;
          do_letter  = 1'b1;
          commit_val = cur_ctrl.neg ? ('0 - cur_acc) : cur_acc;
        end
      end
      default: begin
      end
    endcase

    if (digit_step) begin
      if (acc_next > limit) begin
        emit = 1'b1;
      end else begin
        acc_d        = acc_next[NW-1:0];
        ctrl_d.phase = PH_DIGITS;
      end
    end

    if (do_commit) begin
      ctrl_d.phase = PH_LETTER;
      case (cur_ctrl.pend)
        LT_C: begin
          flags_d.zlib = 1'b1;
          level_d      = commit_val;
        end
        LT_L: begin
          flags_d.lzo = 1'b1;
          level_d     = commit_val;
        end
        LT_E: begin
          flags_d.enc    = 1'b1;
          flags_d.legacy = (commit_val == '0);
          cipher_d       = commit_val;
        end
        default: begin
          if (commit_val != '0) begin
            flags_d.shape = 1'b1;
            speed_d       = commit_val;
          end
        end
      endcase
    end

    if (do_letter) begin
      case (char_i)
        CH_LO_T: flags_d.type_mask[0] = 1'b1;
        CH_LO_P: flags_d.type_mask[1] = 1'b1;
        CH_LO_E: flags_d.type_mask[2] = 1'b1;
        CH_LO_U: flags_d.type_mask[3] = 1'b1;
        CH_UP_T: flags_d.protocol = PROTO_TCP;
        CH_UP_U: flags_d.protocol = PROTO_UDP;
        CH_UP_K: flags_d.keep = 1'b1;
        CH_UP_F: begin
        end
        CH_UP_C, CH_UP_L, CH_UP_E, CH_UP_S: begin
          ctrl_d.phase = PH_FRESH;
          ctrl_d.neg   = 1'b0;
          acc_d        = '0;
          if (char_i == CH_UP_C) begin
            ctrl_d.pend = LT_C;
          end else if (char_i == CH_UP_L) begin
            ctrl_d.pend = LT_L;
          end else if (char_i == CH_UP_E) begin
            ctrl_d.pend = LT_E;
          end else begin
            ctrl_d.pend = LT_S;
          end
        end
        CH_GT: begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end
        default: emit = 1'b1;
      endcase
    end

    if (emit) begin
      ctrl_d.phase = PH_DONE;
    end
  end

  always_comb begin : result_out
    res_valid_o         = emit;
    res_o.ok            = emit_ok;
    res_o.protocol      = flags_d.protocol;
    res_o.type_mask     = flags_d.type_mask;
    res_o.keep_alive    = flags_d.keep;
    res_o.zlib_on       = flags_d.zlib;
    res_o.lzo_on        = flags_d.lzo;
    res_o.comp_level    = FIELD_WIDTH'(level_d);
    res_o.encrypt_on    = flags_d.enc;
    res_o.cipher_code   = FIELD_WIDTH'(cipher_d);
    res_o.legacy_cipher = flags_d.legacy;
    res_o.shape_on      = flags_d.shape;
    res_o.speed_out     = FIELD_WIDTH'(speed_d);
  end

  assign phase_o = ctrl_q.phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '{phase: PH_SEEK, pend: LT_C, neg: 1'b0};
      flags_q  <= '0;
      acc_q    <= '0;
      level_q  <= '0;
      cipher_q <= '0;
      speed_q  <= '0;
    end else if (step_en_i) begin
      ctrl_q   <= ctrl_d;
      flags_q  <= flags_d;
      acc_q    <= acc_d;
      level_q  <= level_d;
      cipher_q <= cipher_d;
      speed_q  <= speed_d;
    end
  end

endmodule

### design/link_option_string_parser.sv
// Top level of the link option string parser: input register, parser core and
// result register with stream handshakes. Depends on lop_pkg and lop_core.
//
// Usage: each slave-side beat carries one byte of an option string in
// s_axis_tdata, and s_axis_tuser is high on the first byte of a new string,
// which clears all parsed values. Bytes before the first '<' are skipped.
// At most one master-side beat is produced per string: when '>' closes a clean
// parse (ok set), or on a NUL, an unknown letter, a missing or overflowing
// number (ok clear). After that, bytes are dropped until the next string start.
// Accepted bytes are registered at the input, results at the output. One byte
// is taken every cycle unless the receiver stalls; the limit is the parse step,
// whose longest path is the times-ten-plus-digit add and the overflow compare.
// Reset returns the parser to the search for '<' with every field cleared.
// When the receiver stalls, the result is held in the output register, one
// more byte waits in the input register, and s_axis_tready then goes low.
`timescale 1ns / 1ps

module link_option_string_parser
  import lop_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,   // char_in[7:0]
  input  logic                      s_axis_tuser,   // start_req
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // ok[0], protocol[2:1], type_mask[6:3], keep_alive[7], zlib_on[8], lzo_on[9],
  // comp_level[41:10], encrypt_on[42], cipher_code[74:43], legacy_cipher[75],
  // shape_on[76], speed_out[108:77], zero[111:109]
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata
);

  logic       in_v_q, in_v_d;
  logic [7:0] in_char_q;
  logic       in_start_q;
  logic       out_v_q, out_v_d;
  result_t    out_res_q;
  logic       advance;
  logic       res_valid;
  result_t    res;
  phase_e     phase;

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign in_v_d        = (s_axis_tvalid && s_axis_tready) || (in_v_q && !advance);
  assign out_v_d       = (advance && res_valid) || (out_v_q && !m_axis_tready);

  lop_core #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (advance),
    .char_i     (in_char_q),
    .start_i    (in_start_q),
    .res_valid_o(res_valid),
    .res_o      (res),
    .phase_o    (phase)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OUT_DATA_WIDTH - RESULT_WIDTH){1'b0}}, out_res_q};

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (phase == PH_DONE) && !in_start_q |-> !res_valid)
    else $error("parser produced a result after the string had ended");

  a_ok_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid && res.ok |-> (in_char_q == CH_GT))
    else $error("successful result without a closing bracket");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_v_q && out_v_q && !m_axis_tready)
    else $error("input stalled while the output stage was free");

  a_legacy_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_res_q.legacy_cipher |-> (out_res_q.cipher_code == '0))
    else $error("legacy cipher reported with a nonzero cipher number");

endmodule

### tb/sv/tb_link_option_string_parser.sv
// Self-checking testbench for link_option_string_parser: option strings go in one
// byte per beat and each result beat is compared with a local parser model.
// Depends on lop_pkg and the link_option_string_parser RTL.
`timescale 1ns / 1ps

module tb_link_option_string_parser;
  import lop_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam int TYPE_TTY   = 0;
  localparam int TYPE_PIPE  = 1;
  localparam int TYPE_ETHER = 2;
  localparam int TYPE_TUN   = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       start;
  } string_byte_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata = '0;
  logic                      s_axis_tuser = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

  string_byte_t pending_bytes[$];
  result_t      expected_results[$];

  // Parser state mirrored from the byte stream.
  phase_e      ps_phase = PH_SEEK;
  letter_e     ps_letter = LT_C;
  logic [32:0] ps_acc = '0;
  logic        ps_neg = 1'b0;
  flags_t      ps_flags = '0;
  logic [31:0] ps_level = '0;
  logic [31:0] ps_cipher = '0;
  logic [31:0] ps_speed = '0;

  logic [7:0] plain_letters[8] = '{CH_LO_T, CH_LO_P, CH_LO_E, CH_LO_U,
                                   CH_UP_T, CH_UP_U, CH_UP_K, CH_UP_F};
  logic [7:0] number_letters[4] = '{CH_UP_C, CH_UP_L, CH_UP_E, CH_UP_S};

  int unsigned cycle_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned live_items = 0;
  int unsigned strings_queued = 0;
  int unsigned results_seen = 0;
  int unsigned ok_results = 0;
  int unsigned mismatch_count = 0;
  logic        count_live = 1'b1;
  logic        start_next = 1'b0;

  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  string_byte_t next_beat;
  stall_mode_e  stall_mode = STALL_NONE;
  int unsigned  stall_left = 0;
  logic         ready_next;
  result_t      seen_result;
  result_t      want_result;

  link_option_string_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic is_blank_char(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit_char(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_sign_char(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS;
  endfunction

  task automatic clear_parser();
    ps_phase  = PH_SEEK;
    ps_letter = LT_C;
    ps_acc    = '0;
    ps_neg    = 1'b0;
    ps_flags  = '0;
    ps_level  = '0;
    ps_cipher = '0;
    ps_speed  = '0;
  endtask

  task automatic close_string(input logic ok);
    result_t r;
    r               = '0;
    r.ok            = ok;
    r.protocol      = ps_flags.protocol;
    r.type_mask     = ps_flags.type_mask;
    r.keep_alive    = ps_flags.keep;
    r.zlib_on       = ps_flags.zlib;
    r.lzo_on        = ps_flags.lzo;
    r.comp_level    = ps_level;
    r.encrypt_on    = ps_flags.enc;
    r.cipher_code   = ps_cipher;
    r.legacy_cipher = ps_flags.legacy;
    r.shape_on      = ps_flags.shape;
    r.speed_out     = ps_speed;
    expected_results.push_back(r);
    ps_phase = PH_DONE;
  endtask

  task automatic commit_number();
    logic [31:0] magnitude;
    logic [31:0] value;
    magnitude = ps_acc[31:0];
    value = ps_neg ? -magnitude : magnitude;
    case (ps_letter)
      LT_C: begin
        ps_flags.zlib = 1'b1;
        ps_level = value;
      end
      LT_L: begin
        ps_flags.lzo = 1'b1;
        ps_level = value;
      end
      LT_E: begin
        ps_flags.enc = 1'b1;
        ps_flags.legacy = (ps_acc == '0);
        ps_cipher = (ps_acc == '0) ? '0 : value;
      end
      default: begin
        if (ps_acc != '0) begin
          ps_flags.shape = 1'b1;
          ps_speed = value;
        end
      end
    endcase
    ps_phase = PH_LETTER;
  endtask

  task automatic decode_letter(input logic [7:0] c);
    case (c)
      CH_LO_T: ps_flags.type_mask[TYPE_TTY] = 1'b1;
      CH_LO_P: ps_flags.type_mask[TYPE_PIPE] = 1'b1;
      CH_LO_E: ps_flags.type_mask[TYPE_ETHER] = 1'b1;
      CH_LO_U: ps_flags.type_mask[TYPE_TUN] = 1'b1;
      CH_UP_T: ps_flags.protocol = PROTO_TCP;
      CH_UP_U: ps_flags.protocol = PROTO_UDP;
      CH_UP_K: ps_flags.keep = 1'b1;
      CH_UP_F: ;
      CH_UP_C, CH_UP_L, CH_UP_E, CH_UP_S: begin
        ps_letter = (c == CH_UP_C) ? LT_C : (c == CH_UP_L) ? LT_L :
                    (c == CH_UP_E) ? LT_E : LT_S;
        ps_phase = PH_FRESH;
        ps_acc = '0;
        ps_neg = 1'b0;
      end
      CH_GT: close_string(1'b1);
      default: close_string(1'b0);
    endcase
  endtask

  task automatic add_digit(input logic [7:0] c);
    logic [63:0] d;
    logic [63:0] lim;
    d = 64'(c) - 64'(CH_ZERO);
    lim = 64'd1 << (NUMBER_WIDTH_DEF - 1);
    if (!ps_neg) lim = lim - 64'd1;
    if (d > lim || {31'd0, ps_acc} > (lim - d) / 64'd10) begin
      close_string(1'b0);
    end else begin
      ps_acc = 33'({31'd0, ps_acc} * 64'd10 + d);
      ps_phase = PH_DIGITS;
    end
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic start);
    if (start) clear_parser();
    case (ps_phase)
      PH_SEEK: begin
        if (c == CH_LT) ps_phase = PH_LETTER;
        else if (c == CH_NUL) close_string(1'b0);
      end
      PH_LETTER: decode_letter(c);
      PH_FRESH, PH_BLANK: begin
        if (is_blank_char(c)) begin
          ps_phase = PH_BLANK;
        end else if (is_sign_char(c)) begin
          ps_neg = (c == CH_MINUS);
          ps_phase = PH_SIGNED;
        end else if (is_digit_char(c)) begin
          add_digit(c);
        end else if (ps_phase == PH_BLANK || ps_letter != LT_E) begin
          close_string(1'b0);
        end else begin
          commit_number();
          decode_letter(c);
        end
      end
      PH_SIGNED: begin
        if (is_digit_char(c)) add_digit(c);
        else close_string(1'b0);
      end
      PH_DIGITS: begin
        if (is_digit_char(c)) begin
          add_digit(c);
        end else begin
          commit_number();
          decode_letter(c);
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] c);
    pending_bytes.push_back('{ch: c, start: start_next});
    start_next = 1'b0;
    bytes_queued++;
    if (count_live) live_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] random_blank();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    return (pick == 5) ? CH_SPACE : 8'(CH_TAB + pick);
  endfunction

  task automatic push_number(input logic [7:0] letter_ch);
    longint unsigned mag;
    int unsigned     pick;
    push_byte(letter_ch);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(random_blank());
    pick = $urandom_range(0, 99);
    if (pick < 25) push_byte(CH_MINUS);
    else if (pick < 40) push_byte(CH_PLUS);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) push_byte(CH_ZERO);
    pick = $urandom_range(0, 99);
    if (pick < 12) mag = 0;
    else if (pick < 35) mag = $urandom_range(1, 9);
    else if (pick < 55) mag = $urandom_range(0, 99999);
    else if (pick < 75) mag = $urandom_range(0, 32'h7fffffff);
    else if (pick < 94) mag = 64'd2147483646 + $urandom_range(0, 3);
    else mag = 64'd99999999999 - $urandom_range(0, 1000);
    push_text($sformatf("%0d", mag));
  endtask

  task automatic push_option_string();
    int unsigned pick;
    int unsigned token;
    logic [7:0]  c;
    strings_queued++;
    start_next = ($urandom_range(0, 19) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        c = 8'($urandom_range(1, 255));
        push_byte((c == CH_LT) ? CH_GT : c);
      end
      if (pick < 9) begin
        push_byte(CH_NUL);
      end else begin
        push_byte(CH_LT);
        repeat ($urandom_range(0, 7)) begin
          token = $urandom_range(0, 99);
          if (token < 45) push_byte(plain_letters[$urandom_range(0, 7)]);
          else if (token < 55) push_byte(CH_UP_E);
          else push_number(number_letters[$urandom_range(0, 3)]);
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          push_byte(CH_GT);
        end else if (pick < 80) begin
          push_byte(CH_NUL);
        end else if (pick < 85) begin
          push_byte(8'($urandom));
        end else if (pick < 90) begin
          push_byte(number_letters[$urandom_range(0, 3)]);
          push_byte(CH_GT);
        end else if (pick < 95) begin
          push_byte(number_letters[$urandom_range(0, 3)]);
          if ($urandom_range(0, 1) == 0) push_byte(random_blank());
          else push_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          push_byte(CH_GT);
        end
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      count_live = 1'b0;
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      count_live = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d, result %0d: %s", cycle_count, results_seen, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is 0x%08h, expected 0x%08h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d bytes accepted, %0d results waiting",
               cycle_count, bytes_accepted, bytes_queued, expected_results.size());
      $display("link_option_string_parser: mismatch");
      $finish;
    end
  end

  // Sender: bursts of beats separated by random gaps, idle data randomized.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tuser);
        bytes_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 || pending_bytes.size() == 0) begin
          if (gap_left != 0) gap_left--;
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= 8'($urandom);
          s_axis_tuser  <= 1'($urandom);
        end else begin
          next_beat = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_beat.ch;
          s_axis_tuser  <= next_beat.start;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 9) == 0) begin
              burst_left = $urandom_range(100, 300);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 24);
              case ($urandom_range(0, 9))
                0, 1, 2: gap_left = 0;
                3, 4, 5, 6, 7: gap_left = $urandom_range(1, 3);
                default: gap_left = $urandom_range(4, 12);
              endcase
            end
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: stall behavior switches between several patterns.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:  ready_next = 1'b1;
        STALL_HALF:  ready_next = 1'($urandom_range(0, 1));
        STALL_HEAVY: ready_next = ($urandom_range(0, 3) == 0);
        default:     ready_next = stall_left[2];
      endcase
      m_axis_tready <= ready_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      seen_result = m_axis_tdata[RESULT_WIDTH-1:0];
      if (m_axis_tdata[OUT_DATA_WIDTH-1:RESULT_WIDTH] != '0) begin
        report_mismatch("padding bits above the result are not zero");
      end
      if (expected_results.size() == 0) begin
        report_mismatch("result beat arrived with no string outstanding");
      end else begin
        want_result = expected_results.pop_front();
        check_field("ok", seen_result.ok, want_result.ok);
        check_field("protocol", seen_result.protocol, want_result.protocol);
        check_field("type_mask", seen_result.type_mask, want_result.type_mask);
        check_field("keep_alive", seen_result.keep_alive, want_result.keep_alive);
        check_field("zlib_on", seen_result.zlib_on, want_result.zlib_on);
        check_field("lzo_on", seen_result.lzo_on, want_result.lzo_on);
        check_field("comp_level", seen_result.comp_level, want_result.comp_level);
        check_field("encrypt_on", seen_result.encrypt_on, want_result.encrypt_on);
        check_field("cipher_code", seen_result.cipher_code, want_result.cipher_code);
        check_field("legacy_cipher", seen_result.legacy_cipher, want_result.legacy_cipher);
        check_field("shape_on", seen_result.shape_on, want_result.shape_on);
        check_field("speed_out", seen_result.speed_out, want_result.speed_out);
        if (want_result.ok) ok_results++;
      end
    end
  end

  initial begin
    // The first string runs on the state left by reset, without a start flag.
    start_next = 1'b0;
    push_text("<tpeuTUKF>");
    start_next = 1'b1;
    push_text("<EC-2147483648>");
    start_next = 1'b1;
    push_text("<S0L+2147483647");
    push_byte(CH_NUL);
    start_next = 1'b1;
    push_text("<C 2147483648>");
    start_next = 1'b1;
    push_text("<S->");
    strings_queued = 5;
    while (live_items < RANDOM_ITEMS + 60) push_option_string();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted != bytes_queued) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) report_mismatch("results still outstanding at the end");

    $display("Sent %0d option strings in %0d bytes over %0d cycles.",
             strings_queued, bytes_queued, cycle_count);
    $display("Checked %0d result beats, %0d clean parses and %0d failures, %0d errors.",
             results_seen, ok_results, results_seen - ok_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("link_option_string_parser: match");
    end else begin
      $display("link_option_string_parser: mismatch");
    end
    $finish;
  end

endmodule

### link_option_string_parser.f
design/lop_pkg.sv
design/lop_core.sv
design/link_option_string_parser.sv
tb/sv/tb_link_option_string_parser.sv
